// ===== hdl/chunked_body_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// chunked_body_decoder_top_macros.svh
// Assertion shorthands for the chunked body decoder, sampled on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chunked body decoder: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chunked body decoder: same-cycle check failed");

`endif

// ===== hdl/cbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, codes and the hex digit decoder of the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned SizeBitsDefault = 32;

  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_EXT     = 3'd2,
    PH_LF      = 3'd3,
    PH_DATA    = 3'd4,
    PH_POST_CR = 3'd5,
    PH_POST_LF = 3'd6,
    PH_HALT    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_FRAME   = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_DONE    = 3'd2,
    ST_ERROR   = 3'd3,
    ST_DROP    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       chunk_last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit; ok is low for any other byte.
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== hdl/chunked_body_decoder_top.sv =====
// A taken word is held in the input register, its result word in the output register.
// Throughput: one word per cycle when not stalled; phase and size counter update in one pass.
// Input and output registers form a two-word pipe: while a result word is stalled,
// one more input word is taken and held, and only then is upstream stalled.
// Reset (rst_ni low, async) empties both stages and returns the parser to the
// start of a size line, count zero.
`timescale 1ns / 1ps
`include "chunked_body_decoder_top_macros.svh"
// ----------------------------------------------------------------------------
// chunked_body_decoder_top
// Byte-serial HTTP chunked body decoder: size line, extension skip, payload
// pass-through with end-of-chunk flag, optional CR LF trailer, zero-size end.
// ----------------------------------------------------------------------------
module chunked_body_decoder_top #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SizeBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cbd_pkg::item_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cbd_pkg::result_t out_data_o
);

  // Input stage.
  logic            in_vld_q;
  cbd_pkg::item_t  in_q;

  // Parser state.
  cbd_pkg::phase_e phase_q, phase_d;
  logic [SIZE_BITS-1:0] count_q, count_d;

  // Output stage.
  logic             out_vld_q;
  cbd_pkg::result_t out_q, res_d;

  // Working copies after an optional new_message restart.
  cbd_pkg::phase_e      phase_w;
  logic [SIZE_BITS-1:0] count_w;
  logic [SIZE_BITS-1:0] count_dec;
  cbd_pkg::hex_t        hex;

  logic advance;   // process the held word into the output register
  logic in_take;   // accept a word from upstream

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Decode: one step of the parser on the held word.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_w   = in_q.new_message ? cbd_pkg::PH_START : phase_q;
    count_w   = in_q.new_message ? '0 : count_q;
    count_dec = count_w - SIZE_BITS'(1);
    hex       = cbd_pkg::hex_decode(in_q.in_byte);

    phase_d          = phase_w;
    count_d          = count_w;
    res_d.out_byte   = 8'd0;
    res_d.status     = cbd_pkg::ST_FRAME;
    res_d.chunk_last = 1'b0;

    case (phase_w)
      cbd_pkg::PH_START: begin
        if (hex.ok) begin
          count_d = SIZE_BITS'(hex.value);
          phase_d = cbd_pkg::PH_DIGITS;
        end else begin
          phase_d      = cbd_pkg::PH_HALT;
          res_d.status = cbd_pkg::ST_ERROR;
        end
      end
      cbd_pkg::PH_DIGITS: begin
        if (hex.ok) begin
          // Overflow when the top nibble is already in use.
          if (count_w[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_d      = cbd_pkg::PH_HALT;
            res_d.status = cbd_pkg::ST_ERROR;
          end else begin
            count_d = {count_w[SIZE_BITS-5:0], hex.value};
          end
        end else if (in_q.in_byte == cbd_pkg::ChCr) begin
          phase_d = cbd_pkg::PH_LF;
        end else begin
          phase_d = cbd_pkg::PH_EXT;
        end
      end
      cbd_pkg::PH_EXT: begin
        if (in_q.in_byte == cbd_pkg::ChCr) begin
          phase_d = cbd_pkg::PH_LF;
        end
      end
      cbd_pkg::PH_LF: begin
        if (in_q.in_byte == cbd_pkg::ChLf) begin
          if (count_w == '0) begin
            phase_d      = cbd_pkg::PH_HALT;
            res_d.status = cbd_pkg::ST_DONE;
          end else begin
            phase_d = cbd_pkg::PH_DATA;
          end
        end else if (in_q.in_byte != cbd_pkg::ChCr) begin
          phase_d = cbd_pkg::PH_EXT;
        end
      end
      cbd_pkg::PH_DATA: begin
        res_d.status   = cbd_pkg::ST_PAYLOAD;
        res_d.out_byte = in_q.in_byte;
        count_d        = count_dec;
        if (count_dec == '0) begin
          res_d.chunk_last = 1'b1;
          phase_d          = cbd_pkg::PH_POST_CR;
        end
      end
      cbd_pkg::PH_POST_CR: begin
        if (in_q.in_byte == cbd_pkg::ChCr) begin
          phase_d = cbd_pkg::PH_POST_LF;
        end else if (hex.ok) begin
          // No trailer: this byte opens the next size line.
          count_d = SIZE_BITS'(hex.value);
          phase_d = cbd_pkg::PH_DIGITS;
        end else begin
          phase_d      = cbd_pkg::PH_HALT;
          res_d.status = cbd_pkg::ST_ERROR;
        end
      end
      cbd_pkg::PH_POST_LF: begin
        if (in_q.in_byte == cbd_pkg::ChLf) begin
          phase_d = cbd_pkg::PH_START;
        end else begin
          phase_d      = cbd_pkg::PH_HALT;
          res_d.status = cbd_pkg::ST_ERROR;
        end
      end
      default: begin
        // Halted: drop everything until a new message.
        res_d.status = cbd_pkg::ST_DROP;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= cbd_pkg::PH_START;
      count_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        phase_q   <= phase_d;
        count_q   <= count_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: input loads on take, output on advance; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `CBD_ASSERT_NEXT(a_halt_after_end,
    advance && (res_d.status == cbd_pkg::ST_DONE || res_d.status == cbd_pkg::ST_ERROR),
    phase_q == cbd_pkg::PH_HALT)
  `CBD_ASSERT_NEXT(a_stay_in_data,
    advance && res_d.status == cbd_pkg::ST_PAYLOAD && !res_d.chunk_last,
    phase_q == cbd_pkg::PH_DATA && count_q != '0)
  `CBD_ASSERT_SAME(a_last_only_payload,
    out_vld_q && out_q.chunk_last,
    out_q.status == cbd_pkg::ST_PAYLOAD)
  `CBD_ASSERT_NEXT(a_held_word_kept,
    in_vld_q && !advance,
    in_vld_q && $stable(in_q))

endmodule
